>>> hdl/cimd_pkg.sv
// Shared types, constants and digit helpers for the IMSI_M digit decoder.
`default_nettype none

package cimd_pkg;

    // Record checks.
    localparam logic [15:0] MIN_LEN     = 16'd10;
    localparam logic [7:0]  PROG_MASK   = 8'h80;
    localparam logic [7:0]  MCC_HI_MASK = 8'h03;
    localparam logic [7:0]  MNC_MASK    = 8'h7F;
    localparam logic [9:0]  MAX3        = 10'd999;
    localparam logic [6:0]  MAX2        = 7'd99;
    localparam logic [3:0]  NIB_MAX     = 4'd10;

    // Output word shape.
    localparam int          NDIGITS   = 15;
    localparam int          CNT_W     = $clog2(NDIGITS);
    localparam logic [7:0]  CHAR_ZERO = 8'h30;

    // Queue between classifier and digit sequencer.
    localparam int QDEPTH = 2;
    localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_NOPROG = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    // One classified record: status plus the fifteen digit codes, first digit at index 0.
    typedef struct packed {
        status_t                     status;
        logic [NDIGITS-1:0][3:0]     codes;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

    // Split a value below 1000 into hundreds, tens and ones.
    function automatic logic [11:0] split3(input logic [9:0] v);
        logic [3:0] h;
        logic [3:0] t;
        logic [9:0] r;
        logic [6:0] rr;
        h = 4'd0;
        t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 10'(k * 100)) begin
                h = 4'(k);
            end
        end
        r  = v - 10'(h) * 10'd100;
        rr = r[6:0];
        for (int k = 1; k <= 9; k++) begin
            if (rr >= 7'(k * 10)) begin
                t = 4'(k);
            end
        end
        return {h, t, 4'(rr - 7'(t) * 7'd10)};
    endfunction

    // A field digit d is sent as (d + 1) mod 10.
    function automatic logic [3:0] shift_code(input logic [3:0] d);
        return (d >= 4'd9) ? 4'd0 : d + 4'd1;
    endfunction

endpackage

`default_nettype wire

>>> hdl/cimd_if.sv
// Handshake interfaces for the record input and the digit output.
`default_nettype none

interface cimd_rec_if;
    logic        valid;
    logic        ready;
    logic [15:0] record_length;
    logic [7:0]  min2_low;
    logic [7:0]  min2_high;
    logic [7:0]  min1_low;
    logic [7:0]  min1_mid;
    logic [7:0]  min1_high;
    logic [7:0]  mnc_byte;
    logic [7:0]  flag_byte;
    logic [7:0]  mcc_low;
    logic [7:0]  mcc_high;

    modport source (
        output valid, record_length, min2_low, min2_high, min1_low, min1_mid,
               min1_high, mnc_byte, flag_byte, mcc_low, mcc_high,
        input  ready
    );
    modport sink (
        input  valid, record_length, min2_low, min2_high, min1_low, min1_mid,
               min1_high, mnc_byte, flag_byte, mcc_low, mcc_high,
        output ready
    );
endinterface

interface cimd_dig_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_char;
    logic [1:0] status;
    logic       last;

    modport source (output valid, digit_char, status, last, input ready);
    modport sink   (input valid, digit_char, status, last, output ready);
endinterface

`default_nettype wire

>>> hdl/cimd_front.sv
// Record front end: accepts a record, checks it and splits its fields into digit codes.
`default_nettype none

module cimd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cimd_rec_if.sink               rec,
    output cimd_pkg::entry_t       wr_data,
    output logic                   push,
    input  wire cimd_pkg::q_flags_t qflags
);

    logic        v_reg, v_next;
    logic        short_reg;
    logic        prog_reg;
    logic [9:0]  mcc_reg;
    logic [6:0]  mnc_reg;
    logic [15:0] min2_reg;
    logic [23:0] min1_reg;
    logic        accept;

    logic [9:0]  upper;
    logic [3:0]  nib;
    logic [9:0]  lower;
    logic [11:0] mcc_s, mnc_s, min2_s, upper_s, lower_s;
    logic        range_bad;

    // Handshake: the holding stage frees up when its word moves into the queue.
    assign push       = v_reg && !qflags.full;
    assign rec.ready  = !v_reg || push;
    assign accept     = rec.valid && rec.ready;

    always_comb
    begin
        v_next = v_reg;
        if (accept) begin
            v_next = 1'b1;
        end else if (push) begin
            v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= v_next;
        end
    end

    // Capture the extracted fields of an accepted record.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            short_reg <= rec.record_length < cimd_pkg::MIN_LEN;
            prog_reg  <= (rec.flag_byte & cimd_pkg::PROG_MASK) != 8'd0;
            mcc_reg   <= {2'(rec.mcc_high & cimd_pkg::MCC_HI_MASK), rec.mcc_low};
            mnc_reg   <= 7'(rec.mnc_byte & cimd_pkg::MNC_MASK);
            min2_reg  <= {rec.min2_high, rec.min2_low};
            min1_reg  <= {rec.min1_high, rec.min1_mid, rec.min1_low};
        end
    end

    // MIN1 breaks into a ten-bit upper part, the thousands nibble and a ten-bit lower part.
    assign upper = min1_reg[23:14];
    assign nib   = min1_reg[13:10];
    assign lower = min1_reg[9:0];

    assign range_bad = (mcc_reg > cimd_pkg::MAX3) || (mnc_reg > cimd_pkg::MAX2) ||
                       (min2_reg > 16'(cimd_pkg::MAX3)) || (nib == 4'd0) ||
                       (nib > cimd_pkg::NIB_MAX) || (upper > cimd_pkg::MAX3) ||
                       (lower > cimd_pkg::MAX3);

    assign mcc_s   = cimd_pkg::split3(mcc_reg);
    assign mnc_s   = cimd_pkg::split3({3'd0, mnc_reg});
    assign min2_s  = cimd_pkg::split3(min2_reg[9:0]);
    assign upper_s = cimd_pkg::split3(upper);
    assign lower_s = cimd_pkg::split3(lower);

    // Build the queue word in IMSI digit order.
    always_comb
    begin
        if (short_reg) begin
            wr_data.status = cimd_pkg::ST_SHORT;
        end else if (!prog_reg) begin
            wr_data.status = cimd_pkg::ST_NOPROG;
        end else if (range_bad) begin
            wr_data.status = cimd_pkg::ST_RANGE;
        end else begin
            wr_data.status = cimd_pkg::ST_OK;
        end

        wr_data.codes[0]  = cimd_pkg::shift_code(mcc_s[11:8]);
        wr_data.codes[1]  = cimd_pkg::shift_code(mcc_s[7:4]);
        wr_data.codes[2]  = cimd_pkg::shift_code(mcc_s[3:0]);
        wr_data.codes[3]  = cimd_pkg::shift_code(mnc_s[7:4]);
        wr_data.codes[4]  = cimd_pkg::shift_code(mnc_s[3:0]);
        wr_data.codes[5]  = cimd_pkg::shift_code(min2_s[11:8]);
        wr_data.codes[6]  = cimd_pkg::shift_code(min2_s[7:4]);
        wr_data.codes[7]  = cimd_pkg::shift_code(min2_s[3:0]);
        wr_data.codes[8]  = cimd_pkg::shift_code(upper_s[11:8]);
        wr_data.codes[9]  = cimd_pkg::shift_code(upper_s[7:4]);
        wr_data.codes[10] = cimd_pkg::shift_code(upper_s[3:0]);
        // The thousands nibble is sent as its value mod 10, without the shift.
        wr_data.codes[11] = (nib == cimd_pkg::NIB_MAX) ? 4'd0 : nib;
        wr_data.codes[12] = cimd_pkg::shift_code(lower_s[11:8]);
        wr_data.codes[13] = cimd_pkg::shift_code(lower_s[7:4]);
        wr_data.codes[14] = cimd_pkg::shift_code(lower_s[3:0]);
    end

endmodule

`default_nettype wire

>>> hdl/cimd_queue.sv
// Small FIFO of classified records between the front end and the digit sequencer.
`default_nettype none

module cimd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cimd_pkg::entry_t   wr_data,
    input  wire logic               pop,
    output cimd_pkg::entry_t        rd_data,
    output cimd_pkg::q_flags_t      flags
);

    localparam logic [cimd_pkg::PTR_W-1:0] PTR_LAST = cimd_pkg::PTR_W'(cimd_pkg::QDEPTH - 1);
    localparam logic [cimd_pkg::PTR_W:0]   CNT_FULL = (cimd_pkg::PTR_W + 1)'(cimd_pkg::QDEPTH);

    cimd_pkg::entry_t               mem_reg [cimd_pkg::QDEPTH];
    logic [cimd_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [cimd_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [cimd_pkg::PTR_W:0]       count_reg, count_next;

    assign flags.full  = count_reg == CNT_FULL;
    assign flags.empty = count_reg == '0;
    assign rd_data     = mem_reg[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for queued words.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !flags.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !flags.empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

>>> hdl/cimd_back.sv
// Digit sequencer: walks the head record, one ASCII word per cycle unless stalled.
`default_nettype none

module cimd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cimd_pkg::entry_t   head,
    input  wire cimd_pkg::q_flags_t qflags,
    output logic                    pop,
    cimd_dig_if.source              dig
);

    localparam logic [cimd_pkg::CNT_W-1:0] LAST_IDX = cimd_pkg::CNT_W'(cimd_pkg::NDIGITS - 1);

    logic [cimd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 char_reg, char_next;
    logic [1:0]                 status_reg, status_next;
    logic                       last_reg, last_next;
    logic                       load;
    logic                       emit;
    logic                       is_err;
    logic                       last_word;

    // The output register reloads when empty or when its word is taken.
    assign load      = !out_valid_reg || dig.ready;
    assign emit      = load && !qflags.empty;
    assign is_err    = head.status != cimd_pkg::ST_OK;
    assign last_word = is_err || (cnt_reg == LAST_IDX);
    assign pop       = emit && last_word;

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        if (load) begin
            out_valid_next = !qflags.empty;
        end
        if (emit) begin
            cnt_next    = last_word ? '0 : cnt_reg + 1'b1;
            char_next   = is_err ? 8'd0 : cimd_pkg::CHAR_ZERO + 8'(head.codes[cnt_reg]);
            status_next = head.status;
            last_next   = last_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign dig.valid      = out_valid_reg;
    assign dig.digit_char = char_reg;
    assign dig.status     = status_reg;
    assign dig.last       = last_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid && (dig.status != 2'(cimd_pkg::ST_OK)) |-> dig.last)
        else $error("error word without last");

    a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg == LAST_IDX) || is_err)
        else $error("record retired before its last digit");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid && !dig.ready |=> $stable(cnt_reg))
        else $error("digit counter moved during a stall");

endmodule

`default_nettype wire

>>> hdl/cdma_imsi_m_to_ascii_digits_top.sv
// CDMA IMSI_M record decoder: takes one record word and sends its IMSI as ASCII digit words.
//
// Input channel rec carries one IMSI_M record (bytes 1 to 9 and the record length) per word.
// Output channel dig carries one word per IMSI digit: digit_char, status and last.
// A good record gives fifteen digit words with status 0, last set on the fifteenth.
// A short, unprogrammed or out-of-range record gives a single word with digit_char 0,
// the status code and last set.
// The record passes the front-end holding stage and the queue before its first digit word is
// registered at the output. The output carries one word per cycle while a record is queued and
// the receiver is ready; the digit sequencer in the back end sets this pace.
// Between the front-end holding stage and a two-word queue, up to three records are
// buffered, so the input keeps taking words while the output drains.
// When the receiver holds ready low the current digit word stays put, the sequencer
// waits, and once the buffering is full rec.ready falls.
// Reset (rst_n, asynchronous, active low) empties every stage and the queue; no word
// is valid after reset until a record is accepted.
`default_nettype none

module cdma_imsi_m_to_ascii_digits_top (
    input  wire logic clk,
    input  wire logic rst_n,
    cimd_rec_if.sink  rec,
    cimd_dig_if.source dig
);

    cimd_pkg::entry_t   wr_data;
    cimd_pkg::entry_t   head;
    cimd_pkg::q_flags_t qflags;
    logic               push;
    logic               pop;

    cimd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec     (rec),
        .wr_data (wr_data),
        .push    (push),
        .qflags  (qflags)
    );

    cimd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_data),
        .pop     (pop),
        .rd_data (head),
        .flags   (qflags)
    );

    cimd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qflags (qflags),
        .pop    (pop),
        .dig    (dig)
    );

endmodule

`default_nettype wire

>>> verif/cdma_imsi_m_to_ascii_digits_top_tb.sv
// Self-checking testbench for the IMSI_M record to ASCII digit decoder.
`timescale 1ns / 100ps

module cdma_imsi_m_to_ascii_digits_top_tb;

    // One IMSI_M record as it travels on the input channel.
    typedef struct packed {
        logic [15:0] record_length;
        logic [7:0]  min2_low;
        logic [7:0]  min2_high;
        logic [7:0]  min1_low;
        logic [7:0]  min1_mid;
        logic [7:0]  min1_high;
        logic [7:0]  mnc_byte;
        logic [7:0]  flag_byte;
        logic [7:0]  mcc_low;
        logic [7:0]  mcc_high;
    } record_t;

    // One digit word as it should appear on the output channel.
    typedef struct packed {
        logic [7:0]        ch;
        cimd_pkg::status_t st;
        logic              last;
    } digit_t;

    localparam int REC_W = $bits(record_t);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cimd_rec_if rec_bus ();
    cimd_dig_if dig_bus ();

    // Testbench-side drivers, known from time zero.
    record_t offer = '0;
    logic    src_valid = 1'b0;
    logic    sink_ready = 1'b0;

    assign rec_bus.valid         = src_valid;
    assign rec_bus.record_length = offer.record_length;
    assign rec_bus.min2_low      = offer.min2_low;
    assign rec_bus.min2_high     = offer.min2_high;
    assign rec_bus.min1_low      = offer.min1_low;
    assign rec_bus.min1_mid      = offer.min1_mid;
    assign rec_bus.min1_high     = offer.min1_high;
    assign rec_bus.mnc_byte      = offer.mnc_byte;
    assign rec_bus.flag_byte     = offer.flag_byte;
    assign rec_bus.mcc_low       = offer.mcc_low;
    assign rec_bus.mcc_high      = offer.mcc_high;
    assign dig_bus.ready         = sink_ready;

    cdma_imsi_m_to_ascii_digits_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rec   (rec_bus),
        .dig   (dig_bus)
    );

    record_t     pending_records[$];
    digit_t      digits_due[$];
    digit_t      next_digit;
    int unsigned fail_count = 0;
    int unsigned records_taken = 0;
    int unsigned sender_idle_pct = 12;
    int unsigned sink_stall_pct = 60;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always #6 clk = ~clk;

    // Digit word bookkeeping for the decoder model.
    function automatic void push_digit(input logic [7:0] ch, input cimd_pkg::status_t st,
                                       input logic last);
        digit_t d;
        d.ch   = ch;
        d.st   = st;
        d.last = last;
        digits_due.push_back(d);
    endfunction

    // A field digit d goes out as the character of (d + 1) mod 10.
    function automatic logic [7:0] field_char(input int d);
        return 8'(int'(cimd_pkg::CHAR_ZERO) + (d + 1) % 10);
    endfunction

    function automatic void push_three(input int v, input logic last_on_ones);
        push_digit(field_char(v / 100), cimd_pkg::ST_OK, 1'b0);
        push_digit(field_char((v / 10) % 10), cimd_pkg::ST_OK, 1'b0);
        push_digit(field_char(v % 10), cimd_pkg::ST_OK, last_on_ones);
    endfunction

    // Works out the digit words that one accepted record must produce.
    function automatic void expect_record(input record_t r);
        logic [23:0] min1;
        int          mcc;
        int          mnc;
        int          min2;
        int          upper;
        int          nib;
        int          lower;
        min1  = {r.min1_high, r.min1_mid, r.min1_low};
        mcc   = int'({r.mcc_high & cimd_pkg::MCC_HI_MASK, r.mcc_low});
        mnc   = int'(r.mnc_byte & cimd_pkg::MNC_MASK);
        min2  = int'({r.min2_high, r.min2_low});
        upper = int'(min1[23:14]);
        nib   = int'(min1[13:10]);
        lower = int'(min1[9:0]);
        if (r.record_length < cimd_pkg::MIN_LEN)
        begin
            push_digit(8'h00, cimd_pkg::ST_SHORT, 1'b1);
        end
        else if ((r.flag_byte & cimd_pkg::PROG_MASK) == 8'h00)
        begin
            push_digit(8'h00, cimd_pkg::ST_NOPROG, 1'b1);
        end
        else if (mcc > int'(cimd_pkg::MAX3) || mnc > int'(cimd_pkg::MAX2) ||
                 min2 > int'(cimd_pkg::MAX3) || nib == 0 || nib > int'(cimd_pkg::NIB_MAX) ||
                 upper > int'(cimd_pkg::MAX3) || lower > int'(cimd_pkg::MAX3))
        begin
            push_digit(8'h00, cimd_pkg::ST_RANGE, 1'b1);
        end
        else
        begin
            push_three(mcc, 1'b0);
            push_digit(field_char(mnc / 10), cimd_pkg::ST_OK, 1'b0);
            push_digit(field_char(mnc % 10), cimd_pkg::ST_OK, 1'b0);
            push_three(min2, 1'b0);
            push_three(upper, 1'b0);
            // The thousands nibble is sent as nib mod 10, without the shift.
            push_digit(8'(int'(cimd_pkg::CHAR_ZERO) + nib % 10), cimd_pkg::ST_OK, 1'b0);
            push_three(lower, 1'b1);
        end
    endfunction

    // Builds a record from field values; unused bits are left clear.
    function automatic record_t build_record(input logic [15:0] len, input logic [9:0] mcc,
                                             input logic [6:0] mnc, input logic [15:0] min2,
                                             input logic [9:0] upper, input logic [3:0] nib,
                                             input logic [9:0] lower, input logic [7:0] flag);
        record_t r;
        r.record_length = len;
        {r.min2_high, r.min2_low} = min2;
        {r.min1_high, r.min1_mid, r.min1_low} = {upper, nib, lower};
        r.mnc_byte  = {1'b0, mnc};
        r.flag_byte = flag;
        r.mcc_low   = mcc[7:0];
        r.mcc_high  = {6'd0, mcc[9:8]};
        return r;
    endfunction

    // A well-formed record with random content; long records are rare.
    function automatic record_t random_good();
        record_t     r;
        logic [15:0] len;
        if ($urandom_range(0, 19) == 0)
        begin
            len = 16'($urandom_range(10, 65535));
        end
        else
        begin
            len = 16'($urandom_range(10, 40));
        end
        r = build_record(len, 10'($urandom_range(0, 999)), 7'($urandom_range(0, 99)),
                         16'($urandom_range(0, 999)), 10'($urandom_range(0, 999)),
                         4'($urandom_range(1, 10)), 10'($urandom_range(0, 999)),
                         {1'b1, 7'($urandom_range(0, 127))});
        r.mnc_byte[7]    = 1'($urandom_range(0, 1));
        r.mcc_high[7:2]  = 6'($urandom_range(0, 63));
        return r;
    endfunction

    // A well-formed record with exactly one defect.
    function automatic record_t random_broken();
        record_t r;
        r = random_good();
        case ($urandom_range(0, 7))
            0: r.record_length = 16'($urandom_range(0, 9));
            1: r.flag_byte[7] = 1'b0;
            2: {r.mcc_high[1:0], r.mcc_low} = 10'($urandom_range(1000, 1023));
            3: r.mnc_byte[6:0] = 7'($urandom_range(100, 127));
            4: {r.min2_high, r.min2_low} = 16'($urandom_range(1000, 65535));
            5: {r.min1_high, r.min1_mid[7:6]} = 10'($urandom_range(1000, 1023));
            6: r.min1_mid[5:2] = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(11, 15));
            default: {r.min1_mid[1:0], r.min1_low} = 10'($urandom_range(1000, 1023));
        endcase
        return r;
    endfunction

    // Mostly good records, some broken ones and some pure noise.
    task automatic queue_random(input int count);
        int      pick;
        record_t r;
        for (int i = 0; i < count; i++)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 70)
            begin
                r = random_good();
            end
            else if (pick < 90)
            begin
                r = random_broken();
            end
            else
            begin
                r = REC_W'({$urandom(), $urandom(), $urandom()});
            end
            pending_records.push_back(r);
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_records.size() != 0 || src_valid || digits_due.size() != 0);
    endtask

    // Record driver: offers the next pending record, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid     <= 1'b0;
            records_taken <= 0;
        end
        else
        begin
            if (src_valid && rec_bus.ready)
            begin
                expect_record(offer);
                records_taken <= records_taken + 1;
            end
            if (!src_valid || rec_bus.ready)
            begin
                if (pending_records.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    offer     <= pending_records.pop_front();
                    src_valid <= 1'b1;
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Digit receiver: random stalls, plus one long hold-off that backs up the block.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            sink_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end
        else if (!hold_done && records_taken >= 40)
        begin
            hold_done  <= 1'b1;
            hold_left  <= 150;
            sink_ready <= 1'b0;
        end
        else
        begin
            sink_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Digit monitor: every accepted word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && dig_bus.valid && sink_ready)
        begin
            if (digits_due.size() == 0)
            begin
                fail_count <= fail_count + 1;
                $display("%0t: expected no word, got char=%h st=%0d last=%b",
                         $realtime, dig_bus.digit_char, dig_bus.status, dig_bus.last);
            end
            else
            begin
                next_digit = digits_due.pop_front();
                if (dig_bus.digit_char !== next_digit.ch || dig_bus.status !== next_digit.st ||
                    dig_bus.last !== next_digit.last)
                begin
                    fail_count <= fail_count + 1;
                    $display("%0t: exp char=%h st=%0d last=%b, got char=%h st=%0d last=%b",
                             $realtime, next_digit.ch, next_digit.st, next_digit.last,
                             dig_bus.digit_char, dig_bus.status, dig_bus.last);
                end
            end
        end
    end

    // Stimulus: directed corner records, then three random phases with different idling.
    initial
    begin
        record_t r;

        // Short records, including one that is also unprogrammed.
        pending_records.push_back(build_record(16'd0, 10'd123, 7'd45, 16'd678, 10'd901, 4'd2,
                                               10'd345, cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd9, 10'd123, 7'd45, 16'd678, 10'd901, 4'd2,
                                               10'd345, 8'h00));
        // Smallest and largest good field values, and a mix of nines and zeros.
        pending_records.push_back(build_record(16'd10, 10'd0, 7'd0, 16'd0, 10'd0, 4'd1, 10'd0,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'hFFFF, 10'd999, 7'd99, 16'd999, 10'd999, 4'd10,
                                               10'd999, 8'hFF));
        pending_records.push_back(build_record(16'd10, 10'd909, 7'd90, 16'd99, 10'd990, 4'd9,
                                               10'd9, cimd_pkg::PROG_MASK));
        // Programmed bit clear.
        pending_records.push_back(build_record(16'd10, 10'd310, 7'd12, 16'd555, 10'd100, 4'd5,
                                               10'd200, 8'h7F));
        // Each field just out of range and at its top; the nibble also at zero.
        pending_records.push_back(build_record(16'd10, 10'd1000, 7'd1, 16'd1, 10'd1, 4'd1, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1023, 7'd1, 16'd1, 10'd1, 4'd1, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd100, 16'd1, 10'd1, 4'd1, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd127, 16'd1, 10'd1, 4'd1, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd1, 16'd1000, 10'd1, 4'd1, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd1, 16'hFFFF, 10'd1, 4'd1, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd1, 16'd1, 10'd1000, 4'd1, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd1, 16'd1, 10'd1023, 4'd1, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd1, 16'd1, 10'd1, 4'd0, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd1, 16'd1, 10'd1, 4'd11, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd1, 16'd1, 10'd1, 4'd15, 10'd1,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd1, 16'd1, 10'd1, 4'd1, 10'd1000,
                                               cimd_pkg::PROG_MASK));
        pending_records.push_back(build_record(16'd10, 10'd1, 7'd1, 16'd1, 10'd1, 4'd1, 10'd1023,
                                               cimd_pkg::PROG_MASK));
        // Unused bits set on an otherwise good record.
        r = build_record(16'd11, 10'd246, 7'd81, 16'd357, 10'd468, 4'd7, 10'd579,
                         cimd_pkg::PROG_MASK);
        r.mcc_high[7:2] = 6'h3F;
        r.mnc_byte[7]   = 1'b1;
        pending_records.push_back(r);
        // Every bit set.
        r = '1;
        pending_records.push_back(r);

        queue_random(100);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        sender_idle_pct = 60;
        sink_stall_pct  = 12;
        queue_random(100);

        wait_drained();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        queue_random(100);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && digits_due.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
